// ===== sv/itp_pkg.sv =====
// shared types, constants and helper functions for the infix to postfix converter
`default_nettype none

package itp_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CLOSE    = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_code_t;

	typedef enum logic [1:0] {
		CLS_OPERAND,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OTHER
	} char_class_t;

	typedef enum logic [1:0] {
		EMIT_CHAR,
		EMIT_TOP,
		EMIT_ERR_CLOSE,
		EMIT_ERR_OVF
	} emit_src_t;

	typedef struct packed {
		logic      load;
		logic      push;
		logic      pop;
		logic      emit;
		emit_src_t src;
		logic      finish;
	} itp_cmd_t;

	typedef struct packed {
		char_class_t cls;
		logic        cnt_zero;
		logic        cnt_full;
		logic        top_open;
		logic        top_ge;
		logic        last;
		logic        stall;
		logic        pend_valid;
	} itp_status_t;

	// precedence shifted up by one so that "none" sits at zero
	function automatic logic [2:0] prec_of(input logic [7:0] c);
		logic [2:0] p;
		p = 3'd0;
		if (c == CH_CARET)
			p = 3'd4;
		else if (c == CH_STAR || c == CH_SLASH)
			p = 3'd3;
		else if (c == CH_PLUS || c == CH_MINUS)
			p = 3'd2;
		return p;
	endfunction

	function automatic char_class_t class_of(input logic [7:0] c);
		char_class_t k;
		if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
				(c >= 8'h30 && c <= 8'h39))
			k = CLS_OPERAND;
		else if (c == CH_LPAREN)
			k = CLS_OPEN;
		else if (c == CH_RPAREN)
			k = CLS_CLOSE;
		else
			k = CLS_OTHER;
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== sv/itp_if.sv =====
// valid/ready channel interfaces for expression characters and postfix results
`default_nettype none

interface itp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       expr_end;

	modport source (output valid, output char_in, output expr_end, input ready);
	modport sink (input valid, input char_in, input expr_end, output ready);
endinterface

interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic [1:0] error_code;
	logic       run_last;

	modport source (output valid, output char_out, output error_code, output run_last,
		input ready);
	modport sink (input valid, input char_out, input error_code, input run_last,
		output ready);
endinterface

`default_nettype wire

// ===== sv/itp_datapath.sv =====
// datapath: item register, operator stack memory, pending result and output register
`default_nettype none

module itp_datapath #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [7:0]          char_in,
	input  wire                 expr_end,
	input  itp_pkg::itp_cmd_t   cmd,
	output itp_pkg::itp_status_t status,
	itp_out_if.source           postfix
);
	import itp_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [7:0]    char_q;
	logic          last_q;
	logic [7:0]    mem [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic [CW-1:0] rd_ptr;
	logic [7:0]    top_q;

	logic          pend_valid_q;
	logic [7:0]    pend_char_q;
	err_code_t     pend_err_q;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	err_code_t     out_err_q;
	logic          out_last_q;
	logic          out_free;

	logic [7:0]    new_char;
	err_code_t     new_err;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= char_in;
			last_q <= expr_end;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.push)
			count_nxt = count_q + CW'(1);
		else if (cmd.pop)
			count_nxt = count_q - CW'(1);
		rd_ptr = count_nxt - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// top_q always mirrors the entry below count_q, a push forwards its own data
	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[count_q[AW-1:0]] <= char_q;
		if (cmd.push)
			top_q <= char_q;
		else if (count_nxt != '0)
			top_q <= mem[rd_ptr[AW-1:0]];
	end

	always_comb begin
		case (cmd.src)
			EMIT_CHAR: begin
				new_char = char_q;
				new_err  = ERR_NONE;
			end
			EMIT_TOP: begin
				new_char = top_q;
				new_err  = ERR_NONE;
			end
			EMIT_ERR_CLOSE: begin
				new_char = 8'd0;
				new_err  = ERR_CLOSE;
			end
			EMIT_ERR_OVF: begin
				new_char = 8'd0;
				new_err  = ERR_OVERFLOW;
			end
			default: begin
				new_char = 8'd0;
				new_err  = ERR_NONE;
			end
		endcase
	end

	assign out_free = !out_valid_q || postfix.ready;

	// one result is held back until it is known whether another follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit)
				pend_valid_q <= 1'b1;
			else if (cmd.finish)
				pend_valid_q <= 1'b0;
			if ((cmd.emit && pend_valid_q) || cmd.finish)
				out_valid_q <= 1'b1;
			else if (postfix.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_char_q <= new_char;
			pend_err_q  <= new_err;
		end
		if ((cmd.emit && pend_valid_q) || cmd.finish) begin
			out_char_q <= pend_char_q;
			out_err_q  <= pend_err_q;
			out_last_q <= cmd.finish;
		end
	end

	assign postfix.valid      = out_valid_q;
	assign postfix.char_out   = out_char_q;
	assign postfix.error_code = out_err_q;
	assign postfix.run_last   = out_last_q;

	always_comb begin
		status.cls        = class_of(char_q);
		status.cnt_zero   = (count_q == '0);
		status.cnt_full   = (count_q == CW'(STACK_DEPTH));
		status.top_open   = (top_q == CH_LPAREN);
		status.top_ge     = (prec_of(top_q) >= prec_of(char_q));
		status.last       = last_q;
		status.stall      = pend_valid_q && !out_free;
		status.pend_valid = pend_valid_q;
	end

endmodule

`default_nettype wire

// ===== sv/itp_ctrl.sv =====
// controller state machine sequencing pushes, pops and result emission
`default_nettype none

module itp_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  itp_pkg::itp_status_t status,
	output itp_pkg::itp_cmd_t    cmd
);
	import itp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WORK,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_nxt;
	state_t after_item;

	always_comb begin
		cmd        = '0;
		cmd.src    = EMIT_CHAR;
		in_ready   = 1'b0;
		state_nxt  = state_q;
		after_item = status.last ? S_FLUSH : S_IDLE;

		case (state_q)
			S_IDLE: begin
				in_ready   = !status.stall;
				cmd.finish = status.pend_valid && !status.stall;
				if (in_valid && !status.stall) begin
					cmd.load  = 1'b1;
					state_nxt = S_WORK;
				end
			end
			S_WORK: begin
				if (!status.stall) begin
					case (status.cls)
						CLS_OPERAND: begin
							cmd.emit  = 1'b1;
							cmd.src   = EMIT_CHAR;
							state_nxt = after_item;
						end
						CLS_OPEN: begin
							if (status.cnt_full) begin
								cmd.emit = 1'b1;
								cmd.src  = EMIT_ERR_OVF;
							end else begin
								cmd.push = 1'b1;
							end
							state_nxt = after_item;
						end
						CLS_CLOSE: begin
							if (status.cnt_zero) begin
								cmd.emit  = 1'b1;
								cmd.src   = EMIT_ERR_CLOSE;
								state_nxt = after_item;
							end else if (status.top_open) begin
								cmd.pop   = 1'b1;
								state_nxt = after_item;
							end else begin
								cmd.emit = 1'b1;
								cmd.src  = EMIT_TOP;
								cmd.pop  = 1'b1;
							end
						end
						CLS_OTHER: begin
							if (!status.cnt_zero && status.top_ge) begin
								cmd.emit = 1'b1;
								cmd.src  = EMIT_TOP;
								cmd.pop  = 1'b1;
							end else begin
								if (status.cnt_full) begin
									cmd.emit = 1'b1;
									cmd.src  = EMIT_ERR_OVF;
								end else begin
									cmd.push = 1'b1;
								end
								state_nxt = after_item;
							end
						end
						default: begin
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_FLUSH: begin
				if (!status.stall) begin
					if (status.cnt_zero) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.emit = 1'b1;
						cmd.src  = EMIT_TOP;
						cmd.pop  = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== sv/infix_to_postfix_converter_top.sv =====
// top level of the shunting-yard infix to postfix converter
//
// channel   dir  payload                          meaning
// expr      in   char_in[7:0], expr_end           one infix character, end marks the last
// postfix   out  char_out[7:0], error_code[1:0],  one postfix character or error,
//                run_last                         run_last on the final one produced for an item
//
// an item is accepted, then worked through one stack step at a time: an operand or push is
// one step, every entry emitted by ')', an operator or the final flush adds a step, and a
// flush adds one more step to see the stack empty.
// the stack is a memory with one registered read port, the top entry held in a register.
// reset clears the stack count and all valid flags; the memory itself is not cleared.
// a stalled postfix channel holds the work once one result waits in the output register
// and one is held back pending; input is taken only between items.
`default_nettype none

module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	itp_in_if.sink    expr,
	itp_out_if.source postfix
);
	import itp_pkg::*;

	itp_cmd_t    cmd;
	itp_status_t status;
	logic        ready;

	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (expr.valid),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	itp_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (expr.char_in),
		.expr_end (expr.expr_end),
		.cmd      (cmd),
		.status   (status),
		.postfix  (postfix)
	);

	assign expr.ready = ready;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !status.cnt_full)
		else $error("push onto a full operator stack");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !status.cnt_zero)
		else $error("pop from an empty operator stack");

	a_no_emit_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !status.stall)
		else $error("result emitted while the output side is blocked");

	a_finish_shows_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (postfix.valid && postfix.run_last))
		else $error("closing result of a transaction not presented with run_last");

endmodule

`default_nettype wire
